// File: src/ssp_pkg.sv
// Shared types and constants of the servo slew tracker.
package ssp_pkg;

  // Angle limits in millidegrees
  localparam logic [17:0] ANGLE_MAX_MDEG = 18'd180000;
  localparam logic [17:0] ANGLE_MID_MDEG = 18'd90000;

  // PWM compare = base + angle/90; angle/90 is floor(angle * RECIP >> SHIFT),
  // exact for all 18-bit angles (2^24 / 44 > 2^18)
  localparam logic [11:0] PWM_BASE  = 12'd500;
  localparam logic [17:0] PWM_RECIP = 18'd186414;
  localparam int          PWM_SHIFT = 24;

  // Stepped mode: fine zone thresholds and steps
  localparam logic signed [19:0] FINE_POS_BIG  = 20'sd20000;
  localparam logic signed [19:0] FINE_POS_MID  = 20'sd2000;
  localparam logic signed [19:0] FINE_POS_SML  = 20'sd400;
  localparam logic signed [19:0] FINE_NEG_BIG  = -20'sd20000;
  localparam logic signed [19:0] FINE_NEG_MID  = -20'sd2000;
  localparam logic signed [19:0] FINE_NEG_SML  = -20'sd400;
  localparam logic signed [19:0] STEP_UP_BIG   = 20'sd200;
  localparam logic signed [19:0] STEP_UP_MID   = 20'sd150;
  localparam logic signed [19:0] STEP_UP_SML   = 20'sd40;
  localparam logic signed [19:0] STEP_DN_BIG   = -20'sd250;
  localparam logic signed [19:0] STEP_DN_MID   = -20'sd150;
  localparam logic signed [19:0] STEP_DN_SML   = -20'sd40;

  // Configuration port
  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_DEADBAND     = 3'd1,
    REG_MAX_RATE     = 3'd2,
    REG_GAIN         = 3'd3,
    REG_COARSE_ZONE  = 3'd4,
    REG_COARSE_STEP  = 3'd5
  } reg_idx_e;

  typedef enum logic {
    MODE_PROP    = 1'b0,
    MODE_STEPPED = 1'b1
  } track_mode_e;

  typedef struct packed {
    track_mode_e mode;
    logic [17:0] deadband_mdeg;
    logic [17:0] max_rate_mdeg;
    logic [15:0] gain_q16;
    logic [17:0] coarse_zone_mdeg;
    logic [17:0] coarse_step_mdeg;
  } cfg_t;

  // Reset values of the configuration registers
  localparam logic [17:0] DEADBAND_RST    = 18'd400;
  localparam logic [17:0] MAX_RATE_RST    = 18'd360;
  localparam logic [15:0] GAIN_RST        = 16'd655;
  localparam logic [17:0] COARSE_ZONE_RST = 18'd30000;
  localparam logic [17:0] COARSE_STEP_RST = 18'd300;

endpackage

// File: src/ssp_if.sv
// Valid/ready channel interfaces for target words and result words.
interface ssp_in_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] target_mdeg;

  modport source (output valid, output target_mdeg, input ready);
  modport sink   (input valid, input target_mdeg, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] angle_mdeg;
  logic [11:0] pwm_compare;

  modport source (output valid, output angle_mdeg, output pwm_compare, input ready);
  modport sink   (input valid, input angle_mdeg, input pwm_compare, output ready);
endinterface

// File: src/ssp_cfg_regs.sv
// APB-style configuration register bank.
module ssp_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ssp_pkg::cfg_t              cfg_o
);

  ssp_pkg::cfg_t     cfg_q;
  ssp_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ssp_pkg::reg_idx_e'(paddr[ssp_pkg::CFG_AW-1:2]);
  assign cfg_o  = cfg_q;

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode             <= ssp_pkg::MODE_PROP;
      cfg_q.deadband_mdeg    <= ssp_pkg::DEADBAND_RST;
      cfg_q.max_rate_mdeg    <= ssp_pkg::MAX_RATE_RST;
      cfg_q.gain_q16         <= ssp_pkg::GAIN_RST;
      cfg_q.coarse_zone_mdeg <= ssp_pkg::COARSE_ZONE_RST;
      cfg_q.coarse_step_mdeg <= ssp_pkg::COARSE_STEP_RST;
    end else if (wr_en) begin
      case (idx)
        ssp_pkg::REG_MODE:        cfg_q.mode <= ssp_pkg::track_mode_e'(pwdata[0]);
        ssp_pkg::REG_DEADBAND:    cfg_q.deadband_mdeg    <= pwdata[17:0];
        ssp_pkg::REG_MAX_RATE:    cfg_q.max_rate_mdeg    <= pwdata[17:0];
        ssp_pkg::REG_GAIN:        cfg_q.gain_q16         <= pwdata[15:0];
        ssp_pkg::REG_COARSE_ZONE: cfg_q.coarse_zone_mdeg <= pwdata[17:0];
        ssp_pkg::REG_COARSE_STEP: cfg_q.coarse_step_mdeg <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = 32'd0;
    case (idx)
      ssp_pkg::REG_MODE:        prdata = {31'd0, cfg_q.mode};
      ssp_pkg::REG_DEADBAND:    prdata = {14'd0, cfg_q.deadband_mdeg};
      ssp_pkg::REG_MAX_RATE:    prdata = {14'd0, cfg_q.max_rate_mdeg};
      ssp_pkg::REG_GAIN:        prdata = {16'd0, cfg_q.gain_q16};
      ssp_pkg::REG_COARSE_ZONE: prdata = {14'd0, cfg_q.coarse_zone_mdeg};
      ssp_pkg::REG_COARSE_STEP: prdata = {14'd0, cfg_q.coarse_step_mdeg};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// File: src/ssp_track.sv
// Input register, angle update logic and current-angle state register.
module ssp_track (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssp_pkg::cfg_t cfg_i,
  ssp_in_if.sink        in_i,
  output logic          valid_o,
  output logic [17:0]   angle_o,
  input  logic          ready_i
);

  logic               a_valid_q;
  logic [17:0]        tgt_q;
  logic [17:0]        tgt_d;
  logic               b_valid_q;
  logic [17:0]        cur_q;
  logic [17:0]        cur_d;
  logic               a_ready;
  logic               b_ready;
  logic               adv;

  logic signed [19:0] err;
  logic signed [19:0] err_neg;
  logic [17:0]        mag;
  logic [17:0]        mag0;
  logic [33:0]        prod;
  logic [17:0]        step_raw;
  logic [17:0]        step_sat;
  logic signed [19:0] step_sat_s;
  logic signed [19:0] cs_s;
  logic signed [19:0] delta;
  logic signed [19:0] sum;

  // Stall chain: a stage takes a word when empty or when its word moves on
  assign b_ready    = !b_valid_q || ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_i.ready = a_ready;
  assign adv        = a_valid_q && b_ready;
  assign valid_o    = b_valid_q;
  assign angle_o    = cur_q;

  // Clamp the incoming target to the legal angle range
  always_comb begin
    if (in_i.target_mdeg[18]) begin
      tgt_d = 18'd0;
    end else if (in_i.target_mdeg[17:0] > ssp_pkg::ANGLE_MAX_MDEG) begin
      tgt_d = ssp_pkg::ANGLE_MAX_MDEG;
    end else begin
      tgt_d = in_i.target_mdeg[17:0];
    end
  end

  // Error and its magnitude
  assign err     = signed'({2'b00, tgt_q}) - signed'({2'b00, cur_q});
  assign err_neg = -err;
  assign mag     = err[19] ? err_neg[17:0] : err[17:0];

  // Proportional step with deadband, truncated toward zero and rate limited
  assign mag0       = (mag < cfg_i.deadband_mdeg) ? 18'd0 : mag;
  assign prod       = {18'd0, cfg_i.gain_q16} * {16'd0, mag0};
  assign step_raw   = prod[33:16];
  assign step_sat   = (step_raw > cfg_i.max_rate_mdeg) ? cfg_i.max_rate_mdeg : step_raw;
  assign step_sat_s = signed'({2'b00, step_sat});
  assign cs_s       = signed'({2'b00, cfg_i.coarse_step_mdeg});

  // Pick the angle change for the active mode
  always_comb begin
    delta = 20'sd0;
    if (cfg_i.mode == ssp_pkg::MODE_PROP) begin
      delta = err[19] ? -step_sat_s : step_sat_s;
    end else if (mag < cfg_i.coarse_zone_mdeg) begin
      if (err > ssp_pkg::FINE_POS_BIG)      delta = ssp_pkg::STEP_UP_BIG;
      else if (err > ssp_pkg::FINE_POS_MID) delta = ssp_pkg::STEP_UP_MID;
      else if (err > ssp_pkg::FINE_POS_SML) delta = ssp_pkg::STEP_UP_SML;
      else if (err < ssp_pkg::FINE_NEG_BIG) delta = ssp_pkg::STEP_DN_BIG;
      else if (err < ssp_pkg::FINE_NEG_MID) delta = ssp_pkg::STEP_DN_MID;
      else if (err < ssp_pkg::FINE_NEG_SML) delta = ssp_pkg::STEP_DN_SML;
      else                                  delta = 20'sd0;
    end else begin
      // Coarse zone: full step, or snap onto the target when close
      if (err > cs_s)       delta = cs_s;
      else if (err < -cs_s) delta = -cs_s;
      else                  delta = err;
    end
  end

  // New angle, clamped
  assign sum = signed'({2'b00, cur_q}) + delta;
  always_comb begin
    if (sum[19]) begin
      cur_d = 18'd0;
    end else if (sum > signed'({2'b00, ssp_pkg::ANGLE_MAX_MDEG})) begin
      cur_d = ssp_pkg::ANGLE_MAX_MDEG;
    end else begin
      cur_d = sum[17:0];
    end
  end

  // Pipeline control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      cur_q     <= ssp_pkg::ANGLE_MID_MDEG;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_i.valid;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (adv) begin
        cur_q <= cur_d;
      end
    end
  end

  // Target register
  always_ff @(posedge clk_i) begin
    if (a_ready && in_i.valid) begin
      tgt_q <= tgt_d;
    end
  end

  // The stored angle never leaves the legal range
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= ssp_pkg::ANGLE_MAX_MDEG)
    else $error("current angle out of range");

  // The angle moves only when a target word is consumed
  a_cur_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cur_q))
    else $error("angle changed without a target word");

  // A target equal to the current angle causes no motion
  a_cur_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (tgt_q == cur_q) |=> $stable(cur_q))
    else $error("angle moved with zero error");

endmodule

// File: src/ssp_pwm_out.sv
// PWM compare computation and result register.
module ssp_pwm_out (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [17:0] angle_i,
  output logic        ready_o,
  ssp_out_if.source   out_o
);

  logic        out_valid_q;
  logic [17:0] angle_q;
  logic [11:0] pwm_q;
  logic [11:0] pwm_d;
  logic [35:0] prod;

  assign ready_o = !out_valid_q || out_o.ready;

  // angle/90 through a reciprocal multiply
  assign prod  = {18'd0, angle_i} * {18'd0, ssp_pkg::PWM_RECIP};
  assign pwm_d = ssp_pkg::PWM_BASE + prod[ssp_pkg::PWM_SHIFT+11:ssp_pkg::PWM_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      angle_q <= angle_i;
      pwm_q   <= pwm_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.angle_mdeg  = angle_q;
  assign out_o.pwm_compare = pwm_q;

  // Compare value stays inside the servo pulse range
  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pwm_q >= 12'd500) && (pwm_q <= 12'd2500))
    else $error("pwm compare out of range");

  // Compare value matches the angle it was computed from
  a_pwm_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((32'(pwm_q) - 32'd500) * 32'd90 <= 32'(angle_q)) &&
                    (32'(angle_q) < (32'(pwm_q) - 32'd500) * 32'd90 + 32'd90))
    else $error("pwm compare does not match angle");

endmodule

// File: src/servo_slew_tracker_pwm_unit.sv
// Servo slew tracker top level: config bank, angle tracker, PWM result stage.
// A target word passes input, current-angle state and PWM result registers.
// Throughput: one target word per cycle unless the output stalls; the angle
// loop closes via the state register; the PWM multiply sits in its own stage.
// Reset: current angle 90000 mdeg, config registers at their reset values,
// pipeline empty; the block takes words from the first cycle after reset.
module servo_slew_tracker_pwm_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  ssp_in_if.sink                     in_i,
  ssp_out_if.source                  out_o
);

  ssp_pkg::cfg_t cfg;
  logic          trk_valid;
  logic [17:0]   trk_angle;
  logic          pwm_ready;

  ssp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssp_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_i    (in_i),
    .valid_o (trk_valid),
    .angle_o (trk_angle),
    .ready_i (pwm_ready)
  );

  ssp_pwm_out u_pwm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trk_valid),
    .angle_i (trk_angle),
    .ready_o (pwm_ready),
    .out_o   (out_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the servo slew tracker: directed and random target words against a predictor.
module tb;

  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_PAD      = 4;
  localparam int LONG_HOLD      = 250;
  localparam int MDEG_PER_COUNT = 90;

  // Indexes past the end of the register list
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [17:0] angle_mdeg;
    logic [11:0] pwm_compare;
  } servo_word_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ssp_pkg::CFG_AW-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  ssp_in_if  in_if ();
  ssp_out_if out_if ();

  servo_slew_tracker_pwm_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Predicted tracker state and register copy
  ssp_pkg::cfg_t tracker_cfg;
  logic [17:0]   tracked_angle;
  servo_word_t   pending_words[$];
  servo_word_t   due_word;

  int send_idle_pct = 34;
  int recv_idle_pct = 77;
  int stall_req     = 0;
  int hold_left     = 0;
  int err_count     = 0;
  int quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // One control tick: clamp the target, move the tracked angle, form the compare value
  function automatic servo_word_t advance_tracker(input logic signed [18:0] tgt);
    longint      amax;
    longint      t;
    longint      cur;
    longint      err;
    longint      mag;
    longint      s;
    longint      next_a;
    servo_word_t w;
    amax = longint'(ssp_pkg::ANGLE_MAX_MDEG);
    t = tgt;
    if (t < 0) t = 0;
    else if (t > amax) t = amax;
    cur = longint'(tracked_angle);
    err = t - cur;
    mag = (err < 0) ? -err : err;
    if (tracker_cfg.mode == ssp_pkg::MODE_STEPPED) begin
      next_a = cur;
      if (mag < longint'(tracker_cfg.coarse_zone_mdeg)) begin
        // fine zone: fixed steps by error band
        if (err > ssp_pkg::FINE_POS_BIG) next_a = cur + ssp_pkg::STEP_UP_BIG;
        else if (err > ssp_pkg::FINE_POS_MID) next_a = cur + ssp_pkg::STEP_UP_MID;
        else if (err > ssp_pkg::FINE_POS_SML) next_a = cur + ssp_pkg::STEP_UP_SML;
        else if (err < ssp_pkg::FINE_NEG_BIG) next_a = cur + ssp_pkg::STEP_DN_BIG;
        else if (err < ssp_pkg::FINE_NEG_MID) next_a = cur + ssp_pkg::STEP_DN_MID;
        else if (err < ssp_pkg::FINE_NEG_SML) next_a = cur + ssp_pkg::STEP_DN_SML;
      end else begin
        s = longint'(tracker_cfg.coarse_step_mdeg);
        if (err > s) next_a = cur + s;
        else if (err < -s) next_a = cur - s;
        else next_a = t;
      end
    end else begin
      // proportional: deadband, Q16 gain on magnitude, rate limit
      if (mag < longint'(tracker_cfg.deadband_mdeg)) mag = 0;
      s = (longint'(tracker_cfg.gain_q16) * mag) >>> 16;
      if (s > longint'(tracker_cfg.max_rate_mdeg)) s = longint'(tracker_cfg.max_rate_mdeg);
      next_a = (err < 0) ? cur - s : cur + s;
    end
    if (next_a < 0) next_a = 0;
    else if (next_a > amax) next_a = amax;
    tracked_angle = next_a[17:0];
    w.angle_mdeg  = next_a[17:0];
    w.pwm_compare = 12'(longint'(ssp_pkg::PWM_BASE) + next_a / MDEG_PER_COUNT);
    return w;
  endfunction

  // Random target: near the current angle, far from it, just off range, or anywhere in range or 19 bits
  function automatic logic signed [18:0] next_target();
    longint v;
    case ($urandom_range(0, 9))
      0: v = longint'($urandom_range(0, 32'h7FFFF)) - 64'sd262144;
      1: begin
        if ($urandom_range(0, 1) == 1) v = -longint'($urandom_range(0, 2000));
        else v = longint'(ssp_pkg::ANGLE_MAX_MDEG) + longint'($urandom_range(0, 2000));
      end
      2, 3, 4, 5: v = longint'(tracked_angle) + longint'($urandom_range(0, 6000)) - 3000;
      6, 7: v = longint'(tracked_angle) + longint'($urandom_range(0, 80000)) - 40000;
      default: v = longint'($urandom_range(0, 180000));
    endcase
    return 19'(v);
  endfunction

  function automatic logic [17:0] pick_span();
    case ($urandom_range(0, 5))
      0: return 18'd0;
      1: return 18'h3FFFF;
      2: return ssp_pkg::ANGLE_MAX_MDEG;
      3: return 18'($urandom_range(0, 2000));
      4: return 18'($urandom_range(0, 40000));
      default: return 18'($urandom);
    endcase
  endfunction

  // All tasks start and end right at a falling edge.
  // Offer one target word, with random idle cycles in front of it
  task automatic send_target(input logic signed [18:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.target_mdeg <= tgt;
    do @(posedge clk_i); while (!in_if.ready);
    pending_words.push_back(advance_tracker(tgt));
    @(negedge clk_i);
  endtask

  task automatic send_offset(input int offset_mdeg);
    send_target(19'(longint'(tracked_angle) + offset_mdeg));
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_PAD) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ssp_pkg::REG_MODE:        tracker_cfg.mode = ssp_pkg::track_mode_e'(value[0]);
      ssp_pkg::REG_DEADBAND:    tracker_cfg.deadband_mdeg    = value[17:0];
      ssp_pkg::REG_MAX_RATE:    tracker_cfg.max_rate_mdeg    = value[17:0];
      ssp_pkg::REG_GAIN:        tracker_cfg.gain_q16         = value[15:0];
      ssp_pkg::REG_COARSE_ZONE: tracker_cfg.coarse_zone_mdeg = value[17:0];
      ssp_pkg::REG_COARSE_STEP: tracker_cfg.coarse_step_mdeg = value[17:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reset settings: field extremes, out-of-range targets, deadband edge
  task automatic test_default_tracking();
    send_target(19'sh40000);
    send_target(19'sd262143);
    send_target(-19'sd1);
    send_target(19'sd180000);
    send_target(19'sd180001);
    send_offset(300);
    send_offset(0);
    send_offset(400);
  endtask

  // Full gain, no deadband, rate limits above range, zero rate, zero gain, huge deadband
  task automatic test_gain_extremes();
    write_reg(ssp_pkg::REG_DEADBAND, 32'd0);
    write_reg(ssp_pkg::REG_GAIN, 32'hFFFF);
    write_reg(ssp_pkg::REG_MAX_RATE, 32'h3FFFF);
    send_target(19'sd0);
    send_target(19'sd180000);
    send_target(19'sd90000);
    write_reg(ssp_pkg::REG_MAX_RATE, 32'd0);
    send_target(19'sd0);
    write_reg(ssp_pkg::REG_MAX_RATE, 32'd180000);
    write_reg(ssp_pkg::REG_GAIN, 32'd0);
    send_target(19'sd0);
    write_reg(ssp_pkg::REG_GAIN, 32'hFFFF);
    write_reg(ssp_pkg::REG_DEADBAND, 32'h3FFFF);
    send_target(19'sd0);
  endtask

  // Every fine band, coarse steps both ways, snap to target, zero coarse zone
  task automatic test_stepped_zones();
    write_reg(ssp_pkg::REG_MODE, 32'(ssp_pkg::MODE_STEPPED));
    send_offset(25000);
    send_offset(5000);
    send_offset(1000);
    send_offset(400);
    send_offset(-25000);
    send_offset(-5000);
    send_offset(-1000);
    send_offset(-400);
    send_offset(45000);
    send_offset(-45000);
    write_reg(ssp_pkg::REG_COARSE_STEP, 32'h3FFFF);
    send_offset(50000);
    write_reg(ssp_pkg::REG_COARSE_ZONE, 32'd0);
    send_offset(-7);
  endtask

  // Writes past the register list must leave every setting alone
  task automatic test_unmapped_writes();
    write_reg(ssp_pkg::REG_MODE, 32'(ssp_pkg::MODE_PROP));
    write_reg(ssp_pkg::REG_DEADBAND, 32'd0);
    write_reg(ssp_pkg::REG_MAX_RATE, 32'd1000);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    send_offset(5000);
    send_offset(-5000);
  endtask

  // Receiver stops for a long stretch while words keep coming, then a full drain and four more words
  task automatic test_long_backpressure();
    stall_req = LONG_HOLD;
    repeat (24) send_target(next_target());
    drain_results();
    repeat (4) send_target(next_target());
  endtask

  // Random targets in chunks, fresh random settings before each chunk
  task automatic test_random_tracking(input int n_words);
    int left;
    int chunk;
    left = n_words;
    while (left > 0) begin
      chunk = $urandom_range(40, 160);
      if (chunk > left) chunk = left;
      write_reg(ssp_pkg::REG_MODE, 32'($urandom_range(0, 1)));
      write_reg(ssp_pkg::REG_DEADBAND, 32'(pick_span()));
      write_reg(ssp_pkg::REG_MAX_RATE, 32'(pick_span()));
      case ($urandom_range(0, 3))
        0: write_reg(ssp_pkg::REG_GAIN, 32'd0);
        1: write_reg(ssp_pkg::REG_GAIN, 32'hFFFF);
        2: write_reg(ssp_pkg::REG_GAIN, 32'($urandom_range(0, 4000)));
        default: write_reg(ssp_pkg::REG_GAIN, 32'($urandom_range(0, 16'hFFFF)));
      endcase
      write_reg(ssp_pkg::REG_COARSE_ZONE, 32'(pick_span()));
      write_reg(ssp_pkg::REG_COARSE_STEP, 32'(pick_span()));
      repeat (chunk) send_target(next_target());
      left -= chunk;
    end
  endtask

  // Receiver ready: long hold when asked, else random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result check against the oldest predicted word
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with none pending: angle_mdeg=%0d pwm_compare=%0d",
               out_if.angle_mdeg, out_if.pwm_compare);
        err_count++;
      end else begin
        due_word = pending_words.pop_front();
        if (out_if.angle_mdeg !== due_word.angle_mdeg) begin
          $error("angle_mdeg: expected %0d, got %0d", due_word.angle_mdeg, out_if.angle_mdeg);
          err_count++;
        end
        if (out_if.pwm_compare !== due_word.pwm_compare) begin
          $error("pwm_compare: expected %0d, got %0d",
                 due_word.pwm_compare, out_if.pwm_compare);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word or register write
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.target_mdeg = '0;
    tracker_cfg.mode             = ssp_pkg::MODE_PROP;
    tracker_cfg.deadband_mdeg    = ssp_pkg::DEADBAND_RST;
    tracker_cfg.max_rate_mdeg    = ssp_pkg::MAX_RATE_RST;
    tracker_cfg.gain_q16         = ssp_pkg::GAIN_RST;
    tracker_cfg.coarse_zone_mdeg = ssp_pkg::COARSE_ZONE_RST;
    tracker_cfg.coarse_step_mdeg = ssp_pkg::COARSE_STEP_RST;
    tracked_angle                = ssp_pkg::ANGLE_MID_MDEG;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 77;
    test_default_tracking();
    test_gain_extremes();
    test_stepped_zones();
    test_unmapped_writes();
    test_random_tracking(520);

    send_idle_pct = 77;
    recv_idle_pct = 34;
    test_long_backpressure();
    test_random_tracking(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_tracking(530);

    drain_results();
    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
